// ----- rtl/core/ets_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ets_pkg;

  localparam int unsigned ETS_TIME_BITS = 32;
  localparam int unsigned EPOCH_BITS    = 32;
  localparam int unsigned REM_BITS      = 17;

  // 86400 = 675 << 7 and 60 = 15 << 2: shift off the power of two, then
  // divide the rest by reciprocal multiply
  localparam int unsigned DAY_PRE   = 7;
  localparam int unsigned MIN_PRE   = 2;
  localparam int unsigned DIV_XW    = EPOCH_BITS - DAY_PRE;
  localparam int unsigned RCP_BITS  = 26;
  localparam int unsigned PROD_BITS = DIV_XW + RCP_BITS;

  localparam logic [DIV_XW-1:0]   DAY_DIV   = DIV_XW'(675);
  localparam logic [DIV_XW-1:0]   MIN_DIV   = DIV_XW'(15);
  localparam logic [DIV_XW-1:0]   WK_DIV    = DIV_XW'(7);
  localparam logic [RCP_BITS-1:0] DAY_RCP   = 26'd50903317;
  localparam logic [RCP_BITS-1:0] MIN_RCP   = 26'd35791395;
  localparam logic [RCP_BITS-1:0] WK_RCP    = 26'd38347923;
  localparam int unsigned         DAY_SHIFT = 35;
  localparam int unsigned         MIN_SHIFT = 29;
  localparam int unsigned         WK_SHIFT  = 28;

  // weekday offset of the epoch: 1970-01-01 was a Thursday
  localparam logic [2:0] EPOCH_WDAY = 3'd4;

  // 1970 modulo 4, 100 and 400
  localparam logic [1:0] EPOCH_MOD4   = 2'd2;
  localparam logic [6:0] EPOCH_MOD100 = 7'd70;
  localparam logic [8:0] EPOCH_MOD400 = 9'd370;

  localparam logic [3:0] MON_FEB = 4'd1;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_SEC,
    DIV_MIN,
    DIV_WDAY
  } div_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAY,
    ST_SEC,
    ST_MIN,
    ST_WDAY,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } ets_state_e;

  typedef struct packed {
    logic     year_init;
    logic     div_load;
    div_sel_e load_sel;
    logic     div_save;
    div_sel_e save_sel;
    logic     year_step;
    logic     month_init;
    logic     month_step;
  } ets_cmd_t;

  typedef struct packed {
    logic div_done;
    logic year_done;
    logic month_done;
  } ets_status_t;

  function automatic logic [4:0] days_in_month(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                    len = 5'd30;
      MON_FEB:                                    len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ets_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ets_ctrl import ets_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  ets_status_t      status_i,
  output ets_cmd_t         cmd_o,
  output logic             busy_o,
  output logic             done_o
);

  ets_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_DAY;
      ST_DAY:   if (status_i.div_done) state_d = ST_SEC;
      ST_SEC:   if (status_i.div_done) state_d = ST_MIN;
      ST_MIN:   if (status_i.div_done) state_d = ST_WDAY;
      ST_WDAY:  if (status_i.div_done) state_d = ST_YEAR;
      ST_YEAR:  if (status_i.year_done) state_d = ST_MONTH;
      ST_MONTH: if (status_i.month_done) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.load_sel = DIV_DAY;
    cmd_o.save_sel = DIV_DAY;
    busy_o = (state_q != ST_IDLE);
    done_o = (state_q == ST_DONE);
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.year_init = 1'b1;
          cmd_o.div_load  = 1'b1;
          cmd_o.load_sel  = DIV_DAY;
        end
      end
      ST_DAY: begin
        if (status_i.div_done) begin
          cmd_o.div_save = 1'b1;
          cmd_o.save_sel = DIV_DAY;
          cmd_o.div_load = 1'b1;
          cmd_o.load_sel = DIV_SEC;
        end
      end
      ST_SEC: begin
        if (status_i.div_done) begin
          cmd_o.div_save = 1'b1;
          cmd_o.save_sel = DIV_SEC;
          cmd_o.div_load = 1'b1;
          cmd_o.load_sel = DIV_MIN;
        end
      end
      ST_MIN: begin
        if (status_i.div_done) begin
          cmd_o.div_save = 1'b1;
          cmd_o.save_sel = DIV_MIN;
          cmd_o.div_load = 1'b1;
          cmd_o.load_sel = DIV_WDAY;
        end
      end
      ST_WDAY: begin
        if (status_i.div_done) begin
          cmd_o.div_save = 1'b1;
          cmd_o.save_sel = DIV_WDAY;
        end
      end
      ST_YEAR: begin
        if (status_i.year_done) begin
          cmd_o.month_init = 1'b1;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        if (!status_i.month_done) begin
          cmd_o.month_step = 1'b1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/ets_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ets_dp import ets_pkg::*; #(
  parameter int unsigned TimeBits = ETS_TIME_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [EPOCH_BITS-1:0] epoch_seconds_i,
  input  ets_cmd_t                   cmd_i,
  output ets_status_t                status_o,
  output logic [5:0]                 second_o,
  output logic [5:0]                 minute_o,
  output logic [4:0]                 hour_o,
  output logic [7:0]                 years_since_1970_o,
  output logic [8:0]                 day_of_year_o,
  output logic [3:0]                 month_o,
  output logic [4:0]                 day_of_month_o,
  output logic [2:0]                 weekday_o
);

  // constant divider: multiply by the reciprocal, then form the remainder
  logic [DIV_XW-1:0]    x_q, x_d;
  logic [DAY_PRE-1:0]   lo_q, lo_d;
  logic [1:0]           step_q, step_d;
  div_sel_e             dsel_q, dsel_d;
  logic [RCP_BITS-1:0]  rcp;
  logic [DIV_XW-1:0]    dconst;
  logic [PROD_BITS-1:0] prod_q;
  logic [DIV_XW-1:0]    quot_sh;
  logic [DIV_XW-1:0]    quot_q, qd_q;
  logic [DIV_XW-1:0]    rsmall;
  logic [REM_BITS-1:0]  rem_w;

  logic [TimeBits-1:0] days_q, d_q;
  logic [5:0]          sec_q, min_q;
  logic [4:0]          hr_q;
  logic [2:0]          wday_q;
  logic [7:0]          year_q;
  logic [1:0]          mod4_q;
  logic [6:0]          mod100_q;
  logic [8:0]          mod400_q;
  logic [8:0]          yday_q, left_q;
  logic [3:0]          mon_q;
  logic                leap;
  logic [8:0]          ylen;
  logic [4:0]          mlen;

  always_comb begin
    case (dsel_q)
      DIV_DAY: begin
        rcp     = DAY_RCP;
        dconst  = DAY_DIV;
        quot_sh = DIV_XW'(prod_q >> DAY_SHIFT);
      end
      DIV_SEC, DIV_MIN: begin
        rcp     = MIN_RCP;
        dconst  = MIN_DIV;
        quot_sh = DIV_XW'(prod_q >> MIN_SHIFT);
      end
      DIV_WDAY: begin
        rcp     = WK_RCP;
        dconst  = WK_DIV;
        quot_sh = DIV_XW'(prod_q >> WK_SHIFT);
      end
      default: begin
        rcp     = DAY_RCP;
        dconst  = DAY_DIV;
        quot_sh = DIV_XW'(prod_q >> DAY_SHIFT);
      end
    endcase
  end

  assign rsmall = x_q - qd_q;

  // put the shifted-off low bits back under the remainder
  always_comb begin
    case (dsel_q)
      DIV_DAY:          rem_w = {rsmall[REM_BITS-DAY_PRE-1:0], lo_q};
      DIV_SEC, DIV_MIN: rem_w = REM_BITS'({rsmall[3:0], lo_q[MIN_PRE-1:0]});
      DIV_WDAY:         rem_w = REM_BITS'(rsmall[2:0]);
      default:          rem_w = '0;
    endcase
  end

  always_comb begin
    x_d    = x_q;
    lo_d   = lo_q;
    step_d = step_q;
    dsel_d = dsel_q;
    if (cmd_i.div_load) begin
      step_d = 2'd2;
      dsel_d = cmd_i.load_sel;
      case (cmd_i.load_sel)
        DIV_DAY: begin
          x_d  = epoch_seconds_i[EPOCH_BITS-1:DAY_PRE];
          lo_d = epoch_seconds_i[DAY_PRE-1:0];
        end
        DIV_SEC: begin
          x_d  = DIV_XW'(rem_w >> MIN_PRE);
          lo_d = DAY_PRE'(rem_w[MIN_PRE-1:0]);
        end
        DIV_MIN: begin
          x_d  = quot_q >> MIN_PRE;
          lo_d = DAY_PRE'(quot_q[MIN_PRE-1:0]);
        end
        DIV_WDAY: begin
          x_d  = DIV_XW'(days_q + TimeBits'(EPOCH_WDAY));
          lo_d = '0;
        end
        default: ;
      endcase
    end else if (step_q != 2'd0) begin
      step_d = step_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      dsel_q <= DIV_DAY;
    end else begin
      step_q <= step_d;
      dsel_q <= dsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    lo_q <= lo_d;
    if (step_q == 2'd2) begin
      prod_q <= PROD_BITS'(x_q) * PROD_BITS'(rcp);
    end
    if (step_q == 2'd1) begin
      quot_q <= quot_sh;
      qd_q   <= quot_sh * dconst;
    end
  end

  // capture each finished quotient and remainder
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_save) begin
      case (cmd_i.save_sel)
        DIV_DAY: days_q <= TimeBits'(quot_q);
        DIV_SEC: sec_q  <= rem_w[5:0];
        DIV_MIN: begin
          min_q <= rem_w[5:0];
          hr_q  <= quot_q[4:0];
        end
        DIV_WDAY: begin
          wday_q <= rem_w[2:0];
          d_q    <= days_q;
        end
        default: ;
      endcase
    end
    if (cmd_i.year_step) begin
      d_q <= d_q - TimeBits'(ylen);
    end
  end

  // year walk with running residues for the leap rule
  assign leap = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);
  assign ylen = leap ? 9'd366 : 9'd365;

  always_ff @(posedge clk_i) begin
    if (cmd_i.year_init) begin
      year_q   <= '0;
      mod4_q   <= EPOCH_MOD4;
      mod100_q <= EPOCH_MOD100;
      mod400_q <= EPOCH_MOD400;
    end else if (cmd_i.year_step) begin
      year_q   <= year_q + 8'd1;
      mod4_q   <= mod4_q + 2'd1;
      mod100_q <= (mod100_q == 7'd99)  ? 7'd0 : mod100_q + 7'd1;
      mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
    end
  end

  // month walk over the remaining days of the year
  assign mlen = days_in_month(mon_q, leap);

  always_ff @(posedge clk_i) begin
    if (cmd_i.month_init) begin
      yday_q <= d_q[8:0];
      left_q <= d_q[8:0];
      mon_q  <= '0;
    end else if (cmd_i.month_step) begin
      left_q <= left_q - 9'(mlen);
      mon_q  <= mon_q + 4'd1;
    end
  end

  assign status_o.div_done   = (step_q == 2'd0);
  assign status_o.year_done  = (d_q < TimeBits'(ylen));
  assign status_o.month_done = (left_q < 9'(mlen));

  assign second_o           = sec_q;
  assign minute_o           = min_q;
  assign hour_o             = hr_q;
  assign years_since_1970_o = year_q;
  assign day_of_year_o      = yday_q;
  assign month_o            = mon_q;
  assign day_of_month_o     = left_q[4:0] + 5'd1;
  assign weekday_o          = wday_q;

endmodule

`default_nettype wire

// ----- rtl/core/epoch_seconds_to_calendar.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Converts seconds since 1970-01-01 00:00:00 UTC into broken-down UTC time.
// Pulse start_i while busy_o is low to hand in an item; busy_o stays high
// through the cycle in which the result appears. The result is valid for
// exactly one cycle while done_o is high; the receiver cannot stall, so capture
// it then. The run time of an item grows with Y, the number of years past 1970
// (up to 136 for a 32-bit input), and with M, the month index (0..11).
// A new item is taken at the earliest in the cycle after the result. The four
// constant divisions (by 86400, 60, 60 and 7) each go through a reciprocal
// multiply with a registered product and a registered quotient; the rest is
// the year-by-year subtraction of 365 or 366 days and the month walk.
module epoch_seconds_to_calendar import ets_pkg::*; #(
  parameter int unsigned TimeBits = ETS_TIME_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [EPOCH_BITS-1:0] epoch_seconds_i,
  output logic                       done_o,
  output logic [5:0]                 second_o,
  output logic [5:0]                 minute_o,
  output logic [4:0]                 hour_o,
  output logic [7:0]                 years_since_1970_o,
  output logic [8:0]                 day_of_year_o,
  output logic [3:0]                 month_o,
  output logic [4:0]                 day_of_month_o,
  output logic [2:0]                 weekday_o
);

  ets_cmd_t    cmd;
  ets_status_t status;

  ets_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  ets_dp #(
    .TimeBits (TimeBits)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .epoch_seconds_i    (epoch_seconds_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .second_o           (second_o),
    .minute_o           (minute_o),
    .hour_o             (hour_o),
    .years_since_1970_o (years_since_1970_o),
    .day_of_year_o      (day_of_year_o),
    .month_o            (month_o),
    .day_of_month_o     (day_of_month_o),
    .weekday_o          (weekday_o)
  );

endmodule

`default_nettype wire

// ----- verif/epoch_seconds_to_calendar_tb.sv -----
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_tb;
  import ets_pkg::*;

  localparam int unsigned RandItems  = 650;
  localparam int unsigned DrainLimit = 2000;
  localparam int unsigned TailCycles = 300;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [7:0] years;
    logic [8:0] yday;
    logic [3:0] month;
    logic [4:0] mday;
    logic [2:0] wday;
  } cal_t;

  typedef struct packed {
    logic [31:0] secs;
    logic        fixed;
    cal_t        cal;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [EPOCH_BITS-1:0] epoch_seconds_i;
  logic                  done_o;
  logic [5:0]            second_o;
  logic [5:0]            minute_o;
  logic [4:0]            hour_o;
  logic [7:0]            years_since_1970_o;
  logic [8:0]            day_of_year_o;
  logic [3:0]            month_o;
  logic [4:0]            day_of_month_o;
  logic [2:0]            weekday_o;

  cal_t     cal_pending[$];
  dir_row_t dir_rows[$];
  int       err_count;
  bit       burst_mode;

  epoch_seconds_to_calendar u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .epoch_seconds_i    (epoch_seconds_i),
    .done_o             (done_o),
    .second_o           (second_o),
    .minute_o           (minute_o),
    .hour_o             (hour_o),
    .years_since_1970_o (years_since_1970_o),
    .day_of_year_o      (day_of_year_o),
    .month_o            (month_o),
    .day_of_month_o     (day_of_month_o),
    .weekday_o          (weekday_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic bit is_leap(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input bit leap);
    int unsigned len;
    case (m)
      3, 5, 8, 10: len = 30;
      MON_FEB:     len = leap ? 29 : 28;
      default:     len = 31;
    endcase
    return len;
  endfunction

  function automatic cal_t calendar_of(input logic [31:0] secs);
    cal_t            c;
    longint unsigned day_count;
    longint unsigned left_days;
    int unsigned     rem;
    int unsigned     yr;
    int unsigned     left;
    int unsigned     len;
    bit              leap;
    bit              found;
    day_count = longint'(secs) / 86400;
    rem       = int'(longint'(secs) % 86400);
    c.second  = 6'(rem % 60);
    c.minute  = 6'((rem / 60) % 60);
    c.hour    = 5'(rem / 3600);
    yr        = 1970;
    leap      = is_leap(yr);
    left_days = day_count;
    while (left_days >= (leap ? 366 : 365)) begin
      left_days -= (leap ? 366 : 365);
      yr++;
      leap = is_leap(yr);
    end
    c.years = 8'(yr - 1970);
    c.yday  = 9'(left_days);
    left    = int'(left_days);
    c.month = '0;
    found   = 1'b0;
    for (int unsigned m = 0; m < 12; m++) begin
      if (!found) begin
        len = month_days(m, leap);
        if (left < len) begin
          c.month = 4'(m);
          found   = 1'b1;
        end else begin
          left -= len;
        end
      end
    end
    c.mday = 5'(left + 1);
    c.wday = 3'((day_count + 4) % 7);
    return c;
  endfunction

  function automatic longint unsigned days_to_year(input int unsigned y);
    longint unsigned acc;
    acc = 0;
    for (int unsigned k = 0; k < y; k++) acc += is_leap(1970 + k) ? 366 : 365;
    return acc;
  endfunction

  function automatic logic [31:0] clip32(input longint v);
    if (v < 0) return 32'($urandom_range(0, 1000));
    if (v > longint'(32'hFFFF_FFFF)) return 32'hFFFF_FFFF - 32'($urandom_range(0, 1000));
    return 32'(v);
  endfunction

  // Bias toward year ends, day ends and the ends of the range.
  function automatic logic [31:0] next_epoch();
    longint base;
    longint off;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom();
    if (sel < 6) begin
      base = longint'(days_to_year($urandom_range(1, 136))) * 86400;
      off  = longint'($urandom_range(0, 4 * 86400)) - 2 * 86400;
      return clip32(base + off);
    end
    if (sel < 8) begin
      base = longint'($urandom_range(0, 49710)) * 86400;
      case ($urandom_range(0, 2))
        0:       off = 0;
        1:       off = 86399;
        default: off = $urandom_range(0, 86399);
      endcase
      return clip32(base + off);
    end
    if (sel == 8) return 32'($urandom_range(0, 200000));
    return 32'hFFFF_FFFF - 32'($urandom_range(0, 5000000));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 6);
    return $urandom_range(40, 400);
  endfunction

  task automatic send_item(input logic [31:0] secs, input cal_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    epoch_seconds_i <= secs;
    // hold the item until the block takes it
    do @(posedge clk_i); while (busy_o);
    cal_pending.push_back(want);
  endtask

  always @(posedge clk_i) begin
    cal_t got;
    cal_t want;
    if (rst_ni && done_o) begin
      got = '{second_o, minute_o, hour_o, years_since_1970_o, day_of_year_o,
              month_o, day_of_month_o, weekday_o};
      if (cal_pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        err_count++;
      end else begin
        want = cal_pending.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          err_count++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned waited;
    cal_t        want;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    epoch_seconds_i = '0;
    err_count       = 0;
    burst_mode      = 1'b0;

    // epoch, last second of the range, day and year ends, leap days, 2100
    dir_rows.push_back('{32'd0, 1'b1,
                         '{6'd0, 6'd0, 5'd0, 8'd0, 9'd0, 4'd0, 5'd1, 3'd4}});
    dir_rows.push_back('{32'hFFFF_FFFF, 1'b1,
                         '{6'd15, 6'd28, 5'd6, 8'd136, 9'd37, 4'd1, 5'd7, 3'd0}});
    dir_rows.push_back('{32'd86399, 1'b1,
                         '{6'd59, 6'd59, 5'd23, 8'd0, 9'd0, 4'd0, 5'd1, 3'd4}});
    dir_rows.push_back('{32'd31535999, 1'b1,
                         '{6'd59, 6'd59, 5'd23, 8'd0, 9'd364, 4'd11, 5'd31, 3'd4}});
    dir_rows.push_back('{32'd31536000, 1'b0, '0});
    dir_rows.push_back('{32'd68169600, 1'b0, '0});
    dir_rows.push_back('{32'd94608000 + 32'd43200, 1'b0, '0});
    dir_rows.push_back('{32'd94694399, 1'b0, '0});
    dir_rows.push_back('{32'd94694400, 1'b0, '0});
    dir_rows.push_back('{32'd951782400, 1'b0, '0});
    dir_rows.push_back('{32'd978220800 + 32'd86399, 1'b0, '0});
    dir_rows.push_back('{32'd2147483647, 1'b0, '0});
    dir_rows.push_back('{32'h8000_0000, 1'b0, '0});
    dir_rows.push_back('{32'd4102444800, 1'b0, '0});
    dir_rows.push_back('{32'd4107456000 + 32'd86399, 1'b0, '0});
    dir_rows.push_back('{32'd4107542400, 1'b0, '0});
    dir_rows.push_back('{32'h5555_5555, 1'b0, '0});
    dir_rows.push_back('{32'hAAAA_AAAA, 1'b0, '0});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst_mode = 1'b1;
    foreach (dir_rows[i]) begin
      want = dir_rows[i].fixed ? dir_rows[i].cal : calendar_of(dir_rows[i].secs);
      send_item(dir_rows[i].secs, want);
      burst_mode = (i < 6);
    end

    for (int unsigned n = 0; n < RandItems; n++) begin
      logic [31:0] secs;
      // switch between gapless stretches and idling ones
      if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
      secs = next_epoch();
      send_item(secs, calendar_of(secs));
    end
    start_i <= 1'b0;

    waited = 0;
    while (cal_pending.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (cal_pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, cal_pending.size());
      err_count++;
    end
    repeat (TailCycles) @(posedge clk_i);

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ets_pkg.sv
rtl/core/ets_ctrl.sv
rtl/core/ets_dp.sv
rtl/core/epoch_seconds_to_calendar.sv
verif/epoch_seconds_to_calendar_tb.sv
